// File: rtl/core/sha256_pkg.sv
package sha256_pkg;

    typedef logic [0:7][31:0] t_hash;

    typedef struct packed {
        logic        push;
        logic [31:0] word;
        logic        start;
        logic        init;
    } t_core_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_sts;

    localparam t_hash HASH_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] PAD_WORD = 32'h8000_0000;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// File: rtl/core/sha256_message_hasher_top.sv
// Channel  Direction  Handshake              Payload
// request  in         in_valid / in_ready    i_msg_word, i_byte_count, i_last_word
// digest   out        out_valid / out_ready  o_digest_word, o_word_index, o_digest_end
//
// A word that does not complete a block is only pushed into the message schedule.
// A word that completes a block starts a compression: 64 rounds of the shared round unit,
// then the hash update, then the hand-back.
// A last word adds pad words and one or two compressions, then eight digest words.
// in_ready is low while a block compresses, and from a last word until the digest is taken;
// out_ready stalls hold the word.
// Reset (synchronous, active low) loads the initial hash and clears fill and length.
module sha256_message_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] i_msg_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_last_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_digest_end
);
    import sha256_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PAD  = 4'b0010,
        ST_COMP = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    logic [3:0]  r_fill, n_fill;
    logic [63:0] r_len, n_len;
    logic        r_pad, n_pad;
    logic        r_pend80, n_pend80;
    logic        r_lenhi, n_lenhi;
    logic        r_lendone, n_lendone;
    logic [2:0]  r_idx, n_idx;

    t_core_ctl   ctl;
    t_core_sts   sts;
    t_hash       hash;

    logic [2:0]  nbytes;
    logic [31:0] last_word_val;

    sha256_compress u_compress (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_sts   (sts),
        .o_hash  (hash)
    );

    assign nbytes = (!i_last_word || i_byte_count > 3'd4) ? 3'd4 : i_byte_count;

    always_comb begin
        case (nbytes)
            3'd0:    last_word_val = PAD_WORD;
            3'd1:    last_word_val = {i_msg_word[31:24], 24'h80_0000};
            3'd2:    last_word_val = {i_msg_word[31:16], 16'h8000};
            3'd3:    last_word_val = {i_msg_word[31:8], 8'h80};
            default: last_word_val = i_msg_word;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_len     = r_len;
        n_pad     = r_pad;
        n_pend80  = r_pend80;
        n_lenhi   = r_lenhi;
        n_lendone = r_lendone;
        n_idx     = r_idx;
        ctl       = '0;
        case (r_state)
            ST_IDLE: begin
                if (in_valid) begin
                    n_len    = r_len + {58'd0, nbytes, 3'b000};
                    ctl.push = 1'b1;
                    ctl.word = last_word_val;
                    n_fill   = r_fill + 4'd1;
                    if (i_last_word) begin
                        n_pad    = 1'b1;
                        n_pend80 = (nbytes == 3'd4);
                    end
                    if (r_fill == 4'd15) begin
                        ctl.start = 1'b1;
                        n_state   = ST_COMP;
                    end else if (i_last_word) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                ctl.push = 1'b1;
                n_fill   = r_fill + 4'd1;
                if (r_pend80) begin
                    ctl.word = PAD_WORD;
                    n_pend80 = 1'b0;
                end else if (r_fill == 4'd14) begin
                    ctl.word = r_len[63:32];
                    n_lenhi  = 1'b1;
                end else if (r_fill == 4'd15 && r_lenhi) begin
                    ctl.word  = r_len[31:0];
                    n_lendone = 1'b1;
                end else begin
                    ctl.word = '0;
                end
                if (r_fill == 4'd15) begin
                    ctl.start = 1'b1;
                    n_state   = ST_COMP;
                end
            end
            ST_COMP: begin
                if (sts.done) begin
                    if (r_lendone) begin
                        n_state = ST_OUT;
                        n_idx   = '0;
                    end else if (r_pad) begin
                        n_state = ST_PAD;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_OUT: begin
                if (out_ready) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        ctl.init  = 1'b1;
                        n_len     = '0;
                        n_pad     = 1'b0;
                        n_pend80  = 1'b0;
                        n_lenhi   = 1'b0;
                        n_lendone = 1'b0;
                        n_state   = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fill    <= '0;
            r_len     <= '0;
            r_pad     <= 1'b0;
            r_pend80  <= 1'b0;
            r_lenhi   <= 1'b0;
            r_lendone <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_len     <= n_len;
            r_pad     <= n_pad;
            r_pend80  <= n_pend80;
            r_lenhi   <= n_lenhi;
            r_lendone <= n_lendone;
            r_idx     <= n_idx;
        end
    end

    assign in_ready      = (r_state == ST_IDLE);
    assign out_valid     = (r_state == ST_OUT);
    assign o_digest_word = hash[r_idx];
    assign o_word_index  = r_idx;
    assign o_digest_end  = (r_idx == 3'd7);

    a_in_out_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_ready && out_valid)) else $error("request taken while digest pending");
    a_comp_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMP && !sts.done) |-> sts.busy || $past(ctl.start))
        else $error("waiting on an idle round unit");
    a_out_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (r_fill == 4'd0 && r_lendone))
        else $error("digest shown before length block done");
    a_digest_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && out_ready && o_digest_end) |=> (in_ready && r_len == 64'd0))
        else $error("no return to idle after digest");

endmodule

// File: rtl/core/sha256_compress.sv
module sha256_compress (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sha256_pkg::t_core_ctl i_ctl,
    output sha256_pkg::t_core_sts o_sts,
    output sha256_pkg::t_hash     o_hash
);
    import sha256_pkg::*;

    logic [31:0] r_w [16];
    t_hash       r_v;
    t_hash       r_h;
    logic [5:0]  r_round;
    logic        r_busy;
    logic        r_add;

    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] choose;
    logic [31:0] major;
    logic [31:0] sched_new;

    assign choose    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign major     = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1        = r_v[7] + big_sigma1(r_v[4]) + choose + ROUND_K[r_round] + r_w[0];
    assign t2        = big_sigma0(r_v[0]) + major;
    assign sched_new = r_w[0] + small_sigma0(r_w[1]) + r_w[9] + small_sigma1(r_w[14]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_add   <= 1'b0;
            r_round <= '0;
            r_h     <= HASH_IV;
        end else begin
            r_add <= 1'b0;
            if (i_ctl.start) begin
                r_busy  <= 1'b1;
                r_round <= '0;
            end else if (r_busy) begin
                r_round <= r_round + 6'd1;
                if (r_round == 6'd63) begin
                    r_busy <= 1'b0;
                    r_add  <= 1'b1;
                end
            end
            if (i_ctl.init) begin
                r_h <= HASH_IV;
            end else if (r_add) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push || r_busy) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= i_ctl.push ? i_ctl.word : sched_new;
        end
        if (i_ctl.start) begin
            r_v <= r_h;
        end else if (r_busy) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_add;
    assign o_hash     = r_h;

    a_busy_add_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_add)) else $error("round and final add overlap");
    a_last_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_round == 6'd63 && !i_ctl.start) |=> r_add)
        else $error("final add missing after last round");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> (!r_busy && !r_add)) else $error("start while busy");
    a_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.push |-> !r_busy) else $error("push during rounds");

endmodule
